// ===== hw/rtl/mprh_pkg.sv =====
package mprh_pkg;

   // Request kinds carried on req_tuser
   typedef enum logic [1:0] {
      ACT_PATTERN_BYTE = 2'd0,
      ACT_PATTERN_LEN  = 2'd1,
      ACT_TEXT_BYTE    = 2'd2,
      ACT_NEW_TEXT     = 2'd3
   } mprh_action_type;

   localparam int ACTION_W   = 2;
   localparam int SLOT_W     = 4;
   localparam int CIDX_W     = 5;
   localparam int BYTE_W     = 8;
   localparam int PLEN_W     = 6;
   localparam int INDEX_W    = 4;
   localparam int POS_W      = 24;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   // Control for the text window shift line
   typedef struct packed {
      logic              shift;
      logic              restart;
      logic [BYTE_W-1:0] text_byte;
   } mprh_win_ctl_type;

endpackage

// ===== hw/rtl/mprh_window.sv =====
module mprh_window #(
   parameter int              MAX_PATTERN_LEN = 32,
   parameter longint unsigned TEXT_LIMIT      = 64'd16777216,
   localparam int             LEN_W           = $clog2(MAX_PATTERN_LEN + 1),
   localparam int             COUNT_W         = $clog2(TEXT_LIMIT + 1)
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  mprh_pkg::mprh_win_ctl_type                  ctl,
   output logic [MAX_PATTERN_LEN-1:0][mprh_pkg::BYTE_W-1:0] window,
   output logic [LEN_W-1:0]                            fill,
   output logic [COUNT_W-1:0]                          count,
   output logic                                        at_limit
);

   logic [MAX_PATTERN_LEN-1:0][mprh_pkg::BYTE_W-1:0] win_ff, win_in;
   logic [LEN_W-1:0]   fill_ff, fill_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // Tap 0 holds the newest byte; each tap hands its byte to the next one
   always_comb begin
      win_in = win_ff;
      if (ctl.shift) begin
         win_in[0] = ctl.text_byte;
         for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
            win_in[i] = win_ff[i-1];
         end
      end
   end

   always_comb begin
      fill_in  = fill_ff;
      count_in = count_ff;
      if (ctl.restart) begin
         fill_in  = '0;
         count_in = '0;
      end else if (ctl.shift) begin
         count_in = count_ff + COUNT_W'(1);
         if (fill_ff != LEN_W'(MAX_PATTERN_LEN)) begin
            fill_in = fill_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   assign window   = win_ff;
   assign fill     = fill_ff;
   assign count    = count_ff;
   assign at_limit = (count_ff == COUNT_W'(TEXT_LIMIT));

endmodule

// ===== hw/rtl/mprh_slot_cell.sv =====
module mprh_slot_cell #(
   parameter int  MAX_PATTERN_LEN = 32,
   localparam int LEN_W           = $clog2(MAX_PATTERN_LEN + 1),
   localparam int IDX_W           = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             wr_byte_en,
   input  logic                                             wr_len_en,
   input  logic [IDX_W-1:0]                                 wr_index,
   input  logic [mprh_pkg::BYTE_W-1:0]                      wr_byte,
   input  logic [LEN_W-1:0]                                 wr_len,
   input  logic [MAX_PATTERN_LEN-1:0][mprh_pkg::BYTE_W-1:0] window,
   input  logic [LEN_W-1:0]                                 fill,
   output logic                                             hit,
   output logic [LEN_W-1:0]                                 len
);

   logic [MAX_PATTERN_LEN-1:0][mprh_pkg::BYTE_W-1:0] pat_ff, pat_in;
   logic [MAX_PATTERN_LEN-1:0][mprh_pkg::BYTE_W-1:0] cmp_ff;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] amount;
   wire  [LEN_W:0][MAX_PATTERN_LEN-1:0][mprh_pkg::BYTE_W-1:0] stage;
   logic [MAX_PATTERN_LEN-1:0] lane_ok;

   always_comb begin
      pat_in = pat_ff;
      if (wr_byte_en) begin
         pat_in[wr_index] = wr_byte;
      end
   end

   assign len_in = wr_len_en ? wr_len : len_ff;

   // Compare image: entry i holds pattern byte len-1-i, so it lines up with window tap i.
   // Reverse the pattern, then shift it down by MAX - len.
   assign amount = LEN_W'(MAX_PATTERN_LEN) - len_in;

   for (genvar j = 0; j < MAX_PATTERN_LEN; j++) begin : g_rev
      assign stage[0][j] = pat_in[MAX_PATTERN_LEN-1-j];
   end

   for (genvar b = 0; b < LEN_W; b++) begin : g_stage
      for (genvar i = 0; i < MAX_PATTERN_LEN; i++) begin : g_lane
         if (i + (1 << b) < MAX_PATTERN_LEN) begin : g_mv
            assign stage[b+1][i] = amount[b] ? stage[b][i + (1 << b)] : stage[b][i];
         end else begin : g_zero
            assign stage[b+1][i] = amount[b] ? '0 : stage[b][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      cmp_ff <= stage[LEN_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   for (genvar i = 0; i < MAX_PATTERN_LEN; i++) begin : g_cmp
      assign lane_ok[i] = (LEN_W'(i) >= len_ff) || (window[i] == cmp_ff[i]);
   end

   assign hit = (len_ff != '0) && (len_ff <= fill) && (&lane_ok);
   assign len = len_ff;

endmodule

// ===== hw/rtl/mprh_emitter.sv =====
module mprh_emitter #(
   parameter int  NUM_SLOTS       = 16,
   parameter int  MAX_PATTERN_LEN = 32,
   parameter int  COUNT_W         = 25,
   localparam int LEN_W           = $clog2(MAX_PATTERN_LEN + 1),
   localparam int SEL_W           = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
   localparam int DIFF_W          = (COUNT_W > mprh_pkg::POS_W) ? COUNT_W : mprh_pkg::POS_W
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic [NUM_SLOTS-1:0]                hits,
   input  logic [NUM_SLOTS-1:0][LEN_W-1:0]     lens,
   input  logic [COUNT_W-1:0]                  count,
   output logic                                load_ok,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mprh_pkg::INDEX_W-1:0]        rsp_index,
   output logic [mprh_pkg::POS_W-1:0]          rsp_pos,
   output logic                                rsp_last
);

   logic [NUM_SLOTS-1:0]            pend_ff, pend_in, pend_after;
   logic [NUM_SLOTS-1:0][LEN_W-1:0] lens_ff;
   logic [COUNT_W-1:0]              count_ff;
   logic                            valid_ff, valid_in;
   logic [mprh_pkg::INDEX_W-1:0]    index_ff;
   logic [mprh_pkg::POS_W-1:0]      pos_ff;
   logic                            last_ff;
   logic [SEL_W-1:0]                sel;
   logic                            found;
   logic                            out_free;
   logic                            emit;
   logic [DIFF_W-1:0]               diff;

   // Lowest pending slot goes out first
   always_comb begin
      sel   = '0;
      found = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (!found && pend_ff[i]) begin
            sel   = SEL_W'(i);
            found = 1'b1;
         end
      end
   end

   assign out_free   = !valid_ff || rsp_ready;
   assign emit       = out_free && found;
   assign pend_after = emit ? (pend_ff & ~(NUM_SLOTS'(1) << sel)) : pend_ff;
   assign load_ok    = (pend_after == '0);
   assign pend_in    = load ? hits : pend_after;
   assign diff       = DIFF_W'(count_ff) - DIFF_W'(lens_ff[sel]);

   always_comb begin
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (out_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lens_ff  <= lens;
         count_ff <= count;
      end
      if (emit) begin
         index_ff <= mprh_pkg::INDEX_W'(sel);
         pos_ff   <= diff[mprh_pkg::POS_W-1:0];
         last_ff  <= (pend_after == '0);
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_index = index_ff;
   assign rsp_pos   = pos_ff;
   assign rsp_last  = last_ff;

endmodule

// ===== hw/rtl/multi_pattern_rolling_hash_matcher_top.sv =====
// Channel | Direction | Ports                      | Contents
// req     | in        | req_tvalid/tready/tuser/tdata | pattern writes, length writes, text
// rsp     | out       | rsp_tvalid/tready/tlast/tdata | one result per matching slot
//
// One request is taken per cycle while req_tready is high. A text byte is compared
// against all slots in the cycle after it is taken, and its hits are loaded into the
// result queue once the queue holds no other pending results; the queue gives one
// result per cycle while rsp_tready is high, and the input stalls while a compared
// byte waits for the queue. Synchronous reset clears slot lengths, the text count
// and all valid flags; pattern bytes are undefined until written.
module multi_pattern_rolling_hash_matcher_top #(
   parameter int              NUM_SLOTS       = 16,
   parameter int              MAX_PATTERN_LEN = 32,
   parameter longint unsigned TEXT_LIMIT      = 64'd16777216
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tuser: action[1:0]
   input  logic [mprh_pkg::ACTION_W-1:0]       req_tuser,
   // tdata: slot[3:0], char_index[8:4], byte_value[16:9], pattern_length[22:17]
   input  logic [mprh_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_tlast,
   // tdata: pattern_index[3:0], match_position[27:4]
   output logic [mprh_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int LEN_W   = $clog2(MAX_PATTERN_LEN + 1);
   localparam int IDX_W   = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
   localparam int COUNT_W = $clog2(TEXT_LIMIT + 1);

   mprh_pkg::mprh_action_type           act;
   logic [mprh_pkg::SLOT_W-1:0]         slot;
   logic [mprh_pkg::CIDX_W-1:0]         cidx;
   logic [mprh_pkg::BYTE_W-1:0]         byte_val;
   logic [mprh_pkg::PLEN_W-1:0]         plen;
   logic [LEN_W-1:0]                    len_sat;
   logic                                accept;
   logic                                is_pbyte, is_plen, is_text, is_restart;
   logic                                cidx_ok;
   logic                                text_take;
   mprh_pkg::mprh_win_ctl_type          win_ctl;

   logic [MAX_PATTERN_LEN-1:0][mprh_pkg::BYTE_W-1:0] window;
   logic [LEN_W-1:0]                    fill;
   logic [COUNT_W-1:0]                  count;
   logic                                at_limit;

   logic [NUM_SLOTS-1:0]                hits;
   logic [NUM_SLOTS-1:0][LEN_W-1:0]     lens;
   logic [NUM_SLOTS-1:0]                wr_byte_en, wr_len_en;

   logic                                cmp_valid_ff, cmp_valid_in;
   logic                                load_ok;
   logic                                load;
   logic [mprh_pkg::INDEX_W-1:0]        rsp_index;
   logic [mprh_pkg::POS_W-1:0]          rsp_pos;

   // Unpack the request
   assign act      = mprh_pkg::mprh_action_type'(req_tuser);
   assign slot     = req_tdata[3:0];
   assign cidx     = req_tdata[8:4];
   assign byte_val = req_tdata[16:9];
   assign plen     = req_tdata[22:17];

   // Hold the input while a compared byte waits for the result queue
   assign req_tready = !cmp_valid_ff || load_ok;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      is_pbyte   = 1'b0;
      is_plen    = 1'b0;
      is_text    = 1'b0;
      is_restart = 1'b0;
      unique case (act)
         mprh_pkg::ACT_PATTERN_BYTE: is_pbyte   = 1'b1;
         mprh_pkg::ACT_PATTERN_LEN:  is_plen    = 1'b1;
         mprh_pkg::ACT_TEXT_BYTE:    is_text    = 1'b1;
         mprh_pkg::ACT_NEW_TEXT:     is_restart = 1'b1;
         default: ;
      endcase
   end

   assign cidx_ok = (32'(cidx) < MAX_PATTERN_LEN);
   // Saturate oversized lengths to the slot depth
   assign len_sat = (32'(plen) > MAX_PATTERN_LEN) ? LEN_W'(MAX_PATTERN_LEN) : LEN_W'(plen);

   // Drop text bytes once the position limit is reached
   assign text_take = accept && is_text && !at_limit;

   assign win_ctl.shift     = text_take;
   assign win_ctl.restart   = accept && is_restart;
   assign win_ctl.text_byte = byte_val;

   mprh_window #(
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
      .TEXT_LIMIT      (TEXT_LIMIT)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .ctl      (win_ctl),
      .window   (window),
      .fill     (fill),
      .count    (count),
      .at_limit (at_limit)
   );

   for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
      assign wr_byte_en[s] = accept && is_pbyte && cidx_ok && (32'(slot) == s);
      assign wr_len_en[s]  = accept && is_plen && (32'(slot) == s);

      mprh_slot_cell #(
         .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_byte_en (wr_byte_en[s]),
         .wr_len_en  (wr_len_en[s]),
         .wr_index   (IDX_W'(cidx)),
         .wr_byte    (byte_val),
         .wr_len     (len_sat),
         .window     (window),
         .fill       (fill),
         .hit        (hits[s]),
         .len        (lens[s])
      );
   end

   // Compare stage: valid while the window holds a byte whose hits are not yet queued
   assign load         = cmp_valid_ff && load_ok;
   assign cmp_valid_in = text_take || (cmp_valid_ff && !load_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   mprh_emitter #(
      .NUM_SLOTS       (NUM_SLOTS),
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
      .COUNT_W         (COUNT_W)
   ) u_emitter (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .hits      (hits),
      .lens      (lens),
      .count     (count),
      .load_ok   (load_ok),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_index (rsp_index),
      .rsp_pos   (rsp_pos),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, rsp_pos, rsp_index};

endmodule
